// ===== src/bfau_pkg.sv =====
// Shared types and constants of the binary field arithmetic unit.
`default_nettype none
package bfau_pkg;

	// Fixed widths of the ports
	localparam int DATA_W      = 8;
	localparam int DEGREE_W    = 4;
	localparam int CFG_IDX_W   = 1;
	localparam int MODE_W      = 2;

	// Default largest field degree
	localparam int DEF_MAX_DEGREE = 8;

	// Reset values of the configuration registers
	localparam logic [DEGREE_W-1:0] RST_DEGREE  = 4'd8;
	localparam logic [DATA_W-1:0]   RST_MODULUS = 8'd27;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIELD_DEGREE = 1'b0,
		REG_MODULUS      = 1'b1
	} cfg_reg_t;

	// Operation codes; the last code is unused and returns zero
	typedef enum logic [MODE_W-1:0] {
		MODE_ADD    = 2'd0,
		MODE_MUL    = 2'd1,
		MODE_DIV    = 2'd2,
		MODE_UNUSED = 2'd3
	} mode_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_TBL,
		ST_SRCH,
		ST_DONE
	} state_t;

	// Datapath operations
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD,
		OP_MUL,
		OP_TBL,
		OP_SRCH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic step_last;
		logic srch_end;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== src/bfau_ctrl.sv =====
// Controller state machine of the binary field arithmetic unit.
`default_nettype none
module bfau_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [bfau_pkg::MODE_W-1:0]  mode,
	input  wire bfau_pkg::dp_stat_t           stat,
	output bfau_pkg::dp_cmd_t                 cmd,
	output logic                              busy,
	output logic                              done
);

	bfau_pkg::state_t state_q;
	bfau_pkg::state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfau_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_nxt = state_q;
		cmd.op    = bfau_pkg::OP_HOLD;
		unique case (state_q)
			bfau_pkg::ST_IDLE: begin
				if (start) begin
					cmd.op = bfau_pkg::OP_LOAD;
					unique case (mode)
						bfau_pkg::MODE_MUL: state_nxt = bfau_pkg::ST_MUL;
						bfau_pkg::MODE_DIV: state_nxt = bfau_pkg::ST_TBL;
						default:            state_nxt = bfau_pkg::ST_DONE;
					endcase
				end
			end
			bfau_pkg::ST_MUL: begin
				cmd.op = bfau_pkg::OP_MUL;
				if (stat.step_last) state_nxt = bfau_pkg::ST_DONE;
			end
			bfau_pkg::ST_TBL: begin
				cmd.op = bfau_pkg::OP_TBL;
				if (stat.step_last) state_nxt = bfau_pkg::ST_SRCH;
			end
			bfau_pkg::ST_SRCH: begin
				cmd.op = bfau_pkg::OP_SRCH;
				if (stat.srch_end) state_nxt = bfau_pkg::ST_MUL;
			end
			bfau_pkg::ST_DONE: begin
				state_nxt = bfau_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = bfau_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != bfau_pkg::ST_IDLE);
	assign done = (state_q == bfau_pkg::ST_DONE);

endmodule
`default_nettype wire

// ===== src/bfau_datapath.sv =====
// Datapath of the binary field arithmetic unit: shift-reduce multiplier and inverse search.
`default_nettype none
module bfau_datapath #(
	parameter int MAX_DEGREE = bfau_pkg::DEF_MAX_DEGREE
) (
	input  wire logic                           clk,
	input  wire bfau_pkg::dp_cmd_t              cmd,
	input  wire logic [bfau_pkg::MODE_W-1:0]    mode,
	input  wire logic [bfau_pkg::DATA_W-1:0]    operand_a,
	input  wire logic [bfau_pkg::DATA_W-1:0]    operand_b,
	input  wire logic [bfau_pkg::DEGREE_W-1:0]  field_degree,
	input  wire logic [bfau_pkg::DATA_W-1:0]    modulus,
	output bfau_pkg::dp_stat_t                  stat,
	output logic [bfau_pkg::DATA_W-1:0]         field_result
);

	localparam int EW = (MAX_DEGREE > bfau_pkg::DATA_W) ? MAX_DEGREE : bfau_pkg::DATA_W;
	localparam int NW = $clog2(MAX_DEGREE + 1);
	localparam int SW = $clog2(MAX_DEGREE);

	logic [NW-1:0] n_q;
	logic [EW-1:0] mask_q;
	logic [EW-1:0] top_q;
	logic [EW-1:0] mod_q;
	logic [EW-1:0] a_q;
	logic [EW-1:0] shift_q;
	logic [EW-1:0] mult_q;
	logic [EW-1:0] acc_q;
	logic [EW-1:0] cand_q;
	logic [EW-1:0] res_q;
	logic [SW-1:0] step_q;
	logic [EW-1:0] rows_q [MAX_DEGREE];

	logic [NW-1:0] n_in;
	logic [EW-1:0] mask_in;
	logic [EW-1:0] a_in;
	logic [EW-1:0] b_in;
	logic [EW-1:0] xtime;
	logic [EW-1:0] acc_nxt;
	logic [EW-1:0] prod;
	logic          hit;
	logic          cand_last;
	logic          step_last;

	// Clamp the degree and build the element mask
	always_comb begin
		if (32'(field_degree) > MAX_DEGREE) begin
			n_in = NW'(MAX_DEGREE);
		end else if (32'(field_degree) < 2) begin
			n_in = NW'(2);
		end else begin
			n_in = NW'(field_degree);
		end
		mask_in = ~({EW{1'b1}} << n_in);
		a_in    = EW'(operand_a) & mask_in;
		b_in    = EW'(operand_b) & mask_in;
	end

	// Multiply by x and reduce; accumulate the selected power
	assign xtime   = ((shift_q << 1) & mask_q) ^ ((|(shift_q & top_q)) ? mod_q : '0);
	assign acc_nxt = mult_q[0] ? (acc_q ^ shift_q) : acc_q;

	// Candidate product: sum of the rows b*x^i picked by the candidate bits
	always_comb begin
		prod = '0;
		for (int i = 0; i < MAX_DEGREE; i++) begin
			if (cand_q[i]) prod = prod ^ rows_q[i];
		end
	end

	assign hit       = (prod == EW'(1));
	assign cand_last = (cand_q == mask_q);
	assign step_last = (NW'(step_q) == n_q - NW'(1));

	assign stat.step_last = step_last;
	assign stat.srch_end  = hit | cand_last;

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			bfau_pkg::OP_LOAD: begin
				n_q     <= n_in;
				mask_q  <= mask_in;
				top_q   <= mask_in ^ (mask_in >> 1);
				mod_q   <= EW'(modulus) & mask_in;
				a_q     <= a_in;
				shift_q <= (mode == bfau_pkg::MODE_DIV) ? b_in : a_in;
				mult_q  <= b_in;
				acc_q   <= '0;
				step_q  <= '0;
				cand_q  <= EW'(1);
				res_q   <= (mode == bfau_pkg::MODE_ADD) ? (a_in ^ b_in) : '0;
			end
			bfau_pkg::OP_MUL: begin
				acc_q   <= acc_nxt;
				shift_q <= xtime;
				mult_q  <= mult_q >> 1;
				step_q  <= step_q + SW'(1);
				if (step_last) res_q <= acc_nxt;
			end
			bfau_pkg::OP_TBL: begin
				rows_q[step_q] <= shift_q;
				shift_q        <= xtime;
				step_q         <= step_q + SW'(1);
			end
			bfau_pkg::OP_SRCH: begin
				// On a hit, set up a times the inverse; if the last candidate misses, set up a times zero
				if (hit || cand_last) begin
					shift_q <= a_q;
					mult_q  <= hit ? cand_q : '0;
					acc_q   <= '0;
					step_q  <= '0;
				end else begin
					cand_q <= cand_q + EW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign field_result = res_q[bfau_pkg::DATA_W-1:0];

endmodule
`default_nettype wire

// ===== src/binary_field_arithmetic_unit.sv =====
// Top level of the binary field arithmetic unit: configuration registers, controller, datapath.
//
// Channel   Direction  Signals                          Transfer
// command   in         start, mode, operand_a/b         start high while busy low
// result    out        done, field_result               done high, one cycle
// config    in         cfg_we, cfg_idx, cfg_wdata       cfg_we high
//
// Add goes from idle straight to the done state; multiply runs the multiply state first.
// Divide tabulates b*x^i for each power below the degree, searches one candidate
// inverse per cycle, then runs the final multiply.
// Reset clears the state machine and loads degree 8 and modulus 0x1B.
// The done strobe is high for a single cycle; busy stays high until it has gone.
`default_nettype none
module binary_field_arithmetic_unit #(
	parameter int MAX_DEGREE = bfau_pkg::DEF_MAX_DEGREE
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [bfau_pkg::MODE_W-1:0]     mode,
	input  wire logic [bfau_pkg::DATA_W-1:0]     operand_a,
	input  wire logic [bfau_pkg::DATA_W-1:0]     operand_b,
	output logic                                 done,
	output logic [bfau_pkg::DATA_W-1:0]          field_result,
	input  wire logic                            cfg_we,
	input  wire logic [bfau_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [bfau_pkg::DATA_W-1:0]     cfg_wdata
);

	logic [bfau_pkg::DEGREE_W-1:0] degree_q;
	logic [bfau_pkg::DATA_W-1:0]   modulus_q;
	bfau_pkg::dp_cmd_t             cmd;
	bfau_pkg::dp_stat_t            stat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q  <= bfau_pkg::RST_DEGREE;
			modulus_q <= bfau_pkg::RST_MODULUS;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				bfau_pkg::REG_FIELD_DEGREE: degree_q  <= cfg_wdata[bfau_pkg::DEGREE_W-1:0];
				bfau_pkg::REG_MODULUS:      modulus_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	bfau_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	bfau_datapath #(
		.MAX_DEGREE (MAX_DEGREE)
	) u_datapath (
		.clk          (clk),
		.cmd          (cmd),
		.mode         (mode),
		.operand_a    (operand_a),
		.operand_b    (operand_b),
		.field_degree (degree_q),
		.modulus      (modulus_q),
		.stat         (stat),
		.field_result (field_result)
	);

endmodule
`default_nettype wire

// ===== src/bfau_checker.sv =====
// Port checker of the binary field arithmetic unit and its bind.
`default_nettype none
module bfau_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           start,
	input wire logic                           busy,
	input wire logic [bfau_pkg::MODE_W-1:0]    mode,
	input wire logic                           done
);

	// A transfer makes the unit busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("unit not busy after a transfer");

	// A result only appears while busy
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	// The strobe lasts one cycle and the unit then goes idle
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe held or unit still busy");

	// Add and the unused code finish in the next cycle
	a_add_fast: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (mode == bfau_pkg::MODE_ADD || mode == bfau_pkg::MODE_UNUSED)
		|=> done)
		else $error("add result late");

endmodule

bind binary_field_arithmetic_unit bfau_checker u_bfau_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.mode   (mode),
	.done   (done)
);
`default_nettype wire
